// File: hw/rtl/utf8_to_ucs2_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder assertion macros
// Clocked implication checks with reset qualification, shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U2_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8U2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/u8u2_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder package
// Byte masks, lead patterns, sequence lengths and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u2_pkg;

    // Sequence lengths reported with each character
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_TWO  = 2'd2;
    localparam logic [1:0] LEN_MAX  = 2'd3;

    // Byte class patterns, compared on the top bits
    localparam logic [1:0] CONT_TAG  = 2'b10;  // 10xxxxxx
    localparam logic [2:0] LEAD2_TAG = 3'b110; // 110xxxxx
    localparam logic [3:0] LEAD3_TAG = 4'b1110; // 1110xxxx

    // Bytes seen in the current string, saturating
    localparam logic [1:0] SEEN_MAX = 2'd3;

    typedef struct packed {
        logic [7:0] prev_byte;
        logic [7:0] prev_prev_byte;
        logic [1:0] seen_count;
    } t_hist;

    typedef struct packed {
        logic        valid;
        logic [15:0] code_unit;
        logic [1:0]  bytes_used;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/u8u2_if.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder stream interfaces
// Valid/ready channels for raw bytes in and decoded characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u2_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_string;

    modport source (output valid, output in_byte, output start_of_string, input ready);
    modport sink   (input valid, input in_byte, input start_of_string, output ready);
endinterface

interface u8u2_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [1:0]  bytes_used;

    modport source (output valid, output code_unit, output bytes_used, input ready);
    modport sink   (input valid, input code_unit, input bytes_used, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/u8u2_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 byte decoder
// Classifies one byte against the two-byte history and builds the character.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u2_decode (
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_sos,
    input  wire u8u2_pkg::t_hist i_hist,
    output u8u2_pkg::t_hist     o_hist,
    output u8u2_pkg::t_result   o_result
);

    logic [7:0] w_b1;
    logic [7:0] w_b2;
    logic [1:0] w_seen;
    logic [1:0] w_seen_n;

    // Clear history when a new string begins
    always_comb begin
        w_b1     = i_sos ? 8'h00 : i_hist.prev_byte;
        w_b2     = i_sos ? 8'h00 : i_hist.prev_prev_byte;
        w_seen   = i_sos ? 2'd0  : i_hist.seen_count;
        w_seen_n = (w_seen == u8u2_pkg::SEEN_MAX) ? u8u2_pkg::SEEN_MAX : w_seen + 2'd1;
    end

    always_comb begin
        o_result.valid      = 1'b0;
        o_result.code_unit  = 16'h0000;
        o_result.bytes_used = u8u2_pkg::LEN_NONE;
        priority if (!i_byte[7]) begin
            o_result.valid      = 1'b1;
            o_result.code_unit  = {8'h00, i_byte};
            o_result.bytes_used = u8u2_pkg::LEN_ONE;
        end else if (i_byte[7:6] == u8u2_pkg::CONT_TAG && w_seen_n >= u8u2_pkg::LEN_TWO) begin
            priority if (w_b1[7:5] == u8u2_pkg::LEAD2_TAG) begin
                o_result.valid      = 1'b1;
                o_result.code_unit  = {5'b00000, w_b1[4:0], i_byte[5:0]};
                o_result.bytes_used = u8u2_pkg::LEN_TWO;
            end else if (w_b1[7:6] == u8u2_pkg::CONT_TAG
                         && w_seen_n == u8u2_pkg::SEEN_MAX
                         && w_b2[7:4] == u8u2_pkg::LEAD3_TAG) begin
                o_result.valid      = 1'b1;
                o_result.code_unit  = {w_b2[3:0], w_b1[5:0], i_byte[5:0]};
                o_result.bytes_used = u8u2_pkg::LEN_MAX;
            end else begin
                o_result.valid = 1'b0;
            end
        end else begin
            o_result.valid = 1'b0;
        end
    end

    // Shift the newest byte into the history on every byte
    always_comb begin
        o_hist.prev_byte      = i_byte;
        o_hist.prev_prev_byte = w_b1;
        o_hist.seen_count     = w_seen_n;
    end

endmodule

`default_nettype wire

// File: hw/rtl/utf8_to_ucs2_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 stream decoder
// Turns a UTF-8 byte stream into 16-bit basic-plane characters.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per beat on i_byte_ch and delivers one 16-bit
// character on o_char_ch whenever the byte completes a one-, two- or
// three-byte sequence, together with the sequence length. Stray leads,
// stray continuation bytes, malformed three-byte leads and four-byte
// sequences produce no beat. Setting start_of_string on a byte clears the
// two-byte history and the byte count before that byte is decoded. The
// block sustains one byte per cycle while the sink keeps up: a byte is
// registered on entry, decoded against the history in one short
// combinational step, and the character lands in the result register,
// from which it is offered on o_char_ch until the sink takes it.
// The result register is the only stall point; while it holds a character
// that the sink has not taken, one more byte can wait in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_ucs2_stream_decoder_assert.svh"

module utf8_to_ucs2_stream_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8u2_byte_if.sink   i_byte_ch,
    u8u2_char_if.source o_char_ch
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sos;

    // Decode history
    u8u2_pkg::t_hist r_hist;
    u8u2_pkg::t_hist n_hist;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_out_code;
    logic [1:0]  r_out_len;

    u8u2_pkg::t_result w_res;
    logic              w_adv;

    // Advance the held byte when the result register is free or draining
    assign w_adv           = r_in_valid && (!r_out_valid || o_char_ch.ready);
    assign i_byte_ch.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_in_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_ch.valid && i_byte_ch.ready) begin
            r_in_byte <= i_byte_ch.in_byte;
            r_in_sos  <= i_byte_ch.start_of_string;
        end
    end

    u8u2_decode u_decode (
        .i_byte   (r_in_byte),
        .i_sos    (r_in_sos),
        .i_hist   (r_hist),
        .o_hist   (n_hist),
        .o_result (w_res)
    );

    // Update history on every decoded byte, whether it emits or not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (w_adv) begin
            r_hist <= n_hist;
        end
    end

    // Load a character, drop the slot once the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end else if (o_char_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out_code <= w_res.code_unit;
            r_out_len  <= w_res.bytes_used;
        end
    end

    assign o_char_ch.valid      = r_out_valid;
    assign o_char_ch.code_unit  = r_out_code;
    assign o_char_ch.bytes_used = r_out_len;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `U8U2_ASSERT_NEXT(a_seen_nonzero, i_clk, i_rst_n,
        w_adv, r_hist.seen_count != 2'd0,
        "byte count zero after a decoded byte")
    `U8U2_ASSERT_NOW(a_len_nonzero, i_clk, i_rst_n,
        r_out_valid, r_out_len != u8u2_pkg::LEN_NONE,
        "character beat with zero length")
    `U8U2_ASSERT_NOW(a_three_needs_count, i_clk, i_rst_n,
        w_adv && w_res.valid && w_res.bytes_used == u8u2_pkg::LEN_MAX,
        n_hist.seen_count == u8u2_pkg::SEEN_MAX,
        "three-byte character before three bytes seen")
    `U8U2_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        r_in_valid && !w_adv, !i_byte_ch.ready,
        "byte taken while input register is stalled")
    `U8U2_ASSERT_NOW(a_ascii_range, i_clk, i_rst_n,
        r_out_valid && r_out_len == u8u2_pkg::LEN_ONE, r_out_code[15:7] == 9'd0,
        "one-byte character above 0x7f")

endmodule

`default_nettype wire

// File: tb/tb_utf8_to_ucs2_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 stream decoder testbench
// Streams directed and random UTF-8 bytes into the decoder, with random
// gaps on the byte side and random stalls on the character side. A
// tracker class keeps its own copy of the two-byte history and the byte
// count, predicts every character, and checks each delivered beat in order.
// ----------------------------------------------------------------------------

// Expected character, one per completed sequence
typedef struct {
    logic [15:0] code_unit;
    logic [1:0]  bytes_used;
} t_ucs2_char;

// Keeps the decode history and the queue of characters still owed by the block.
class ucs2_char_tracker;
    logic [7:0]  last_byte      = '0;
    logic [7:0]  older_byte     = '0;
    logic [1:0]  string_count   = '0;
    t_ucs2_char  pending_chars[$];
    int unsigned mismatches     = 0;

    // Decode one accepted byte against the history and queue any character.
    function void take_byte(logic [7:0] b, logic sos);
        t_ucs2_char ch;
        logic       emit;
        emit = 1'b0;
        ch.code_unit  = '0;
        ch.bytes_used = u8u2_pkg::LEN_NONE;
        if (sos) begin
            last_byte    = '0;
            older_byte   = '0;
            string_count = '0;
        end
        if (string_count != u8u2_pkg::SEEN_MAX)
            string_count = string_count + 2'd1;

        if (!b[7]) begin
            ch.code_unit  = {8'h00, b};
            ch.bytes_used = u8u2_pkg::LEN_ONE;
            emit = 1'b1;
        end else if (b[7:6] == u8u2_pkg::CONT_TAG && string_count >= u8u2_pkg::LEN_TWO) begin
            if (last_byte[7:5] == u8u2_pkg::LEAD2_TAG) begin
                ch.code_unit  = {5'b0, last_byte[4:0], b[5:0]};
                ch.bytes_used = u8u2_pkg::LEN_TWO;
                emit = 1'b1;
            end else if (last_byte[7:6] == u8u2_pkg::CONT_TAG
                         && string_count == u8u2_pkg::SEEN_MAX
                         && older_byte[7:4] == u8u2_pkg::LEAD3_TAG) begin
                ch.code_unit  = {older_byte[3:0], last_byte[5:0], b[5:0]};
                ch.bytes_used = u8u2_pkg::LEN_MAX;
                emit = 1'b1;
            end
        end

        older_byte = last_byte;
        last_byte  = b;
        if (emit)
            pending_chars.push_back(ch);
    endfunction

    // Compare one delivered character with the oldest expectation.
    function void check_char(logic [15:0] code_unit, logic [1:0] bytes_used);
        t_ucs2_char want;
        if (pending_chars.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected character: expected none, actual %h len %0d",
                     $time, code_unit, bytes_used);
            return;
        end
        want = pending_chars.pop_front();
        if (code_unit !== want.code_unit) begin
            mismatches++;
            $display("%0t: code_unit mismatch: expected %h, actual %h",
                     $time, want.code_unit, code_unit);
        end
        if (bytes_used !== want.bytes_used) begin
            mismatches++;
            $display("%0t: bytes_used mismatch: expected %0d, actual %0d",
                     $time, want.bytes_used, bytes_used);
        end
    endfunction
endclass

module tb_utf8_to_ucs2_stream_decoder;

    localparam int unsigned RANDOM_BYTES = 1550;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned SETTLE_CYCLES = 8;
    // Four-byte lead pattern, only used to build sequences the block must drop
    localparam logic [4:0]  LEAD4_TAG = 5'b11110;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Cleared in stretches where both sides should run flat out
    logic allow_idle = 1'b1;

    int unsigned bytes_sent = 0;

    u8u2_byte_if byte_ch();
    u8u2_char_if char_ch();

    ucs2_char_tracker tracker = new;

    utf8_to_ucs2_stream_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte_ch(byte_ch),
        .o_char_ch(char_ch)
    );

    always #2 i_clk = ~i_clk;

    // Hold reset once, at the start of the run.
    initial begin
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!allow_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte after a random gap; return at the edge that takes it.
    task automatic send_byte(input logic [7:0] b, input logic sos);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid           <= 1'b1;
        byte_ch.in_byte         <= b;
        byte_ch.start_of_string <= sos;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Build one random item of the stream: a well-formed character most of
    // the time, otherwise a dropped four-byte sequence, a truncated sequence
    // or raw noise. Send it with start_of_string on the first byte at times,
    // and on broken items sometimes on an inner byte.
    task automatic send_random_item();
        logic [7:0]  seq[$];
        int unsigned kind;
        int unsigned sos_at;
        int unsigned i;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            seq.push_back({1'b0, 7'($urandom)});
        end else if (kind < 50) begin
            seq.push_back({u8u2_pkg::LEAD2_TAG, 5'($urandom)});
            seq.push_back({u8u2_pkg::CONT_TAG, 6'($urandom)});
        end else if (kind < 75) begin
            seq.push_back({u8u2_pkg::LEAD3_TAG, 4'($urandom)});
            seq.push_back({u8u2_pkg::CONT_TAG, 6'($urandom)});
            seq.push_back({u8u2_pkg::CONT_TAG, 6'($urandom)});
        end else if (kind < 82) begin
            seq.push_back({LEAD4_TAG, 3'($urandom)});
            repeat (3) seq.push_back({u8u2_pkg::CONT_TAG, 6'($urandom)});
        end else if (kind < 90) begin
            // Truncated lead: two- or three-byte lead missing its last byte
            if ($urandom_range(0, 1) == 0) begin
                seq.push_back({u8u2_pkg::LEAD2_TAG, 5'($urandom)});
            end else begin
                seq.push_back({u8u2_pkg::LEAD3_TAG, 4'($urandom)});
                seq.push_back({u8u2_pkg::CONT_TAG, 6'($urandom)});
            end
        end else begin
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
        end

        sos_at = seq.size();
        if ($urandom_range(0, 19) == 0)
            sos_at = 0;
        else if (kind >= 75 && $urandom_range(0, 9) == 0)
            sos_at = $urandom_range(0, seq.size() - 1);

        for (i = 0; i < seq.size(); i++)
            send_byte(seq[i], i == sos_at);
    endtask

    // Character sink: random stalls, held high through quiet stretches.
    initial begin : char_sink
        int unsigned stall;
        char_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            stall = pick_gap();
            if (stall != 0) begin
                char_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            char_ch.ready <= 1'b1;
        end
    end

    // Observe both channels at each edge: predict on every byte beat,
    // check on every character beat.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready)
            tracker.take_byte(byte_ch.in_byte, byte_ch.start_of_string);
        if (i_rst_n && char_ch.valid && char_ch.ready)
            tracker.check_char(char_ch.code_unit, char_ch.bytes_used);
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned waited;
        byte_ch.valid           <= 1'b0;
        byte_ch.in_byte         <= '0;
        byte_ch.start_of_string <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // Single bytes: zero, top of ASCII, a plain letter
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h41, 1'b0);
        // Two-byte characters, lowest and highest payload
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Three-byte lead with one continuation emits nothing, the second completes
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        // Largest three-byte character
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Two-byte character followed by a stray continuation
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'h80, 1'b0);
        // Four-byte sequence is dropped whole
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // Lead interrupted by ASCII, then a bare 0xFF byte
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Stray continuation as the first byte of a string
        send_byte(8'h80, 1'b1);
        // New string cuts a three-byte sequence: too few bytes seen
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hAC, 1'b0);
        // Lead as first byte of a string still completes
        send_byte(8'hED, 1'b1);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hBF, 1'b0);

        // Random part: switch quiet stretches on and off now and then.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 99) == 0)
                allow_idle = ~allow_idle;
            send_random_item();
        end
        byte_ch.valid <= 1'b0;

        // Drain with the sink held ready, then let the pipeline settle.
        allow_idle = 1'b0;
        waited = 0;
        while (tracker.pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending_chars.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
